// ----- rtl/ept_pkg.sv -----
`timescale 1ns / 1ps

package ept_pkg;

  localparam int TIME_W = 64;
  localparam int WIN_W  = 31;
  localparam int CODE_W = 8;
  localparam int CFG_AW = 2;

  typedef enum logic [CFG_AW-1:0] {
    CFG_MIN_INTERVAL  = 2'd0,
    CFG_SILENT_WINDOW = 2'd1,
    CFG_EXEMPT_TYPE   = 2'd2
  } cfg_reg_t;

  localparam logic [CODE_W-1:0] EXEMPT_RESET = 8'hFF;

  // True when a stored send time is still inside an enabled window.
  // A stored time of zero means never sent; a clock that ran backwards counts
  // as zero elapsed time.
  function automatic logic too_soon(input logic [TIME_W-1:0] now_t,
                                    input logic [TIME_W-1:0] then_t,
                                    input logic [WIN_W-1:0]  win);
    logic [TIME_W-1:0] elapsed;
    elapsed = (now_t >= then_t) ? (now_t - then_t) : '0;
    return (win != '0) && (then_t != '0) &&
           (elapsed < {{(TIME_W-WIN_W){1'b0}}, win});
  endfunction

endpackage

// ----- rtl/ept_ram.sv -----
`timescale 1ns / 1ps

module ept_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic                                     rd_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- rtl/event_push_throttle_top.sv -----
`timescale 1ns / 1ps
// Channel | Dir | Handshake           | Payload
// in_     | in  | in_tvalid/in_tready | tdata: event_channel, event_type, now_time
// out_    | out | out_tvalid/out_tready | tdata: allow
// cfg_    | in  | cfg_we              | cfg_addr selects register, cfg_wdata
//
// Per event: table read on accept, then decision and write-back; a new event
// can be accepted every cycle unless the output stalls, and a same-slot write
// from the previous event is forwarded around the table's registered read port.
// After reset the table is swept to zero, one entry per cycle, over all
// NUM_CHANNELS*NUM_TYPES entries (128 by default) while in_tready stays low.
// A stalled result holds in the output register; the decision stage holds
// behind it and in_tready drops only when both are full.

module event_push_throttle_top
  import ept_pkg::*;
#(
  parameter int NUM_CHANNELS = 16,
  parameter int NUM_TYPES    = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [79:0]       in_tdata,   // [7:0] event_channel, [15:8] event_type,
                                        // [79:16] now_time
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [7:0]        out_tdata,  // [0] allow, [7:1] zero
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [WIN_W-1:0]  cfg_wdata
);

  localparam int TABLE_SIZE = NUM_CHANNELS * NUM_TYPES;
  localparam int AW = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam logic [AW-1:0] CLR_LAST = AW'(TABLE_SIZE - 1);

  // configuration
  logic [WIN_W-1:0]  min_interval_r;
  logic [WIN_W-1:0]  silent_window_r;
  logic [CODE_W-1:0] exempt_type_r;

  // input decode
  logic [CODE_W-1:0] ch_raw, ty_raw;
  logic [TIME_W-1:0] in_now;
  logic              ch_ok, ty_ok;
  logic [6:0]        ch_idx, ty_idx;
  logic [12:0]       slot_full;
  logic [AW-1:0]     in_slot;
  logic              in_exempt;
  logic              in_fire;

  // decision stage
  logic              s1_valid_r;
  logic [AW-1:0]     s1_slot_r;
  logic [TIME_W-1:0] s1_now_r;
  logic              s1_exempt_r;
  logic              s1_adv;
  logic [TIME_W-1:0] tbl_rd_data;
  logic [TIME_W-1:0] slot_time;
  logic              allow;

  // write forwarding, global time, table clear
  logic              fwd_valid_r;
  logic [AW-1:0]     fwd_slot_r;
  logic [TIME_W-1:0] fwd_time_r;
  logic [TIME_W-1:0] glob_time_r;
  logic              clr_busy_r;
  logic [AW-1:0]     clr_cnt_r;

  logic              tbl_we;
  logic [AW-1:0]     tbl_waddr;
  logic [TIME_W-1:0] tbl_wdata;

  logic              out_valid_r;
  logic              out_allow_r;

  assign ch_raw = in_tdata[7:0];
  assign ty_raw = in_tdata[15:8];
  assign in_now = in_tdata[79:16];

  // negative or too large codes fall back to index 0
  assign ch_ok  = !ch_raw[7] && (ch_raw < 8'(NUM_CHANNELS));
  assign ty_ok  = !ty_raw[7] && (ty_raw < 8'(NUM_TYPES));
  assign ch_idx = ch_ok ? ch_raw[6:0] : '0;
  assign ty_idx = ty_ok ? ty_raw[6:0] : '0;
  assign slot_full = 13'(ch_idx) * 13'(NUM_TYPES) + 13'(ty_idx);
  assign in_slot   = slot_full[AW-1:0];

  // signed type against unsigned register: codes 128..255 never match
  assign in_exempt = !ty_raw[7] && (ty_raw == exempt_type_r);

  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !clr_busy_r && (!s1_valid_r || s1_adv);
  assign in_fire   = in_tvalid && in_tready;

  assign slot_time = (fwd_valid_r && (fwd_slot_r == s1_slot_r)) ? fwd_time_r : tbl_rd_data;
  assign allow = s1_exempt_r ||
                 (!too_soon(s1_now_r, slot_time, silent_window_r) &&
                  !too_soon(s1_now_r, glob_time_r, min_interval_r));

  assign tbl_we    = clr_busy_r || (s1_adv && allow);
  assign tbl_waddr = clr_busy_r ? clr_cnt_r : s1_slot_r;
  assign tbl_wdata = clr_busy_r ? '0 : s1_now_r;

  ept_ram #(
    .WIDTH (TIME_W),
    .DEPTH (TABLE_SIZE)
  ) u_table (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (tbl_waddr),
    .wr_data (tbl_wdata),
    .rd_en   (in_fire),
    .rd_addr (in_slot),
    .rd_data (tbl_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_interval_r  <= '0;
      silent_window_r <= '0;
      exempt_type_r   <= EXEMPT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MIN_INTERVAL:  min_interval_r  <= cfg_wdata;
        CFG_SILENT_WINDOW: silent_window_r <= cfg_wdata;
        CFG_EXEMPT_TYPE:   exempt_type_r   <= cfg_wdata[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_cnt_r == CLR_LAST) begin
        clr_busy_r <= 1'b0;
      end else begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_slot_r   <= in_slot;
      s1_now_r    <= in_now;
      s1_exempt_r <= in_exempt;
    end
  end

  // a back-to-back event reads the table on the same edge as this write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
      glob_time_r <= '0;
    end else if (s1_adv) begin
      fwd_valid_r <= allow;
      if (allow) begin
        glob_time_r <= s1_now_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      fwd_slot_r <= s1_slot_r;
      fwd_time_r <= s1_now_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_allow_r <= allow;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_allow_r};

endmodule

// ----- rtl/ept_checker.sv -----
`timescale 1ns / 1ps

module ept_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata
);

  // table sweep keeps the input closed right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> !in_tready)
    else $error("input ready during table clear");

  // an accepted event with a free output reaches the output register
  a_result_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) ##1 (!out_tvalid || out_tready) |=> out_tvalid)
    else $error("result missing two cycles after transfer");

  // only the allow bit may be set
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[7:1] == 7'd0))
    else $error("padding bits set in result");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("stalled result changed");

endmodule

bind event_push_throttle_top ept_checker u_ept_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
